/* rtl/mors_pkg.sv */
// Shared types and constants for the magnetometer outlier-reject smoother.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package mors_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values, and ALPHA_ONE, the alpha value that stands for one.
  localparam logic [8:0]  ALPHA_RESET     = 9'd46;
  localparam logic [15:0] NORM_MIN_RESET  = 16'd140;
  localparam logic [15:0] NORM_MAX_RESET  = 16'd1300;
  localparam logic [15:0] JUMP_RESET      = 16'd4000;
  localparam logic [15:0] POLL_RESET      = 16'd30;
  localparam logic [8:0]  ALPHA_ONE       = 9'd256;

  // Bit positions in the sensor status byte.
  localparam int STATUS_DRDY_BIT = 0;
  localparam int STATUS_OVF_BIT  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_Q8      = 3'd0,
    CFG_NORM_MIN      = 3'd1,
    CFG_NORM_MAX      = 3'd2,
    CFG_JUMP_LIMIT    = 3'd3,
    CFG_POLL_INTERVAL = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OC_UPDATED   = 3'd0,
    OC_NOT_DUE   = 3'd1,
    OC_BUS_FAIL  = 3'd2,
    OC_NOT_READY = 3'd3,
    OC_OVERFLOW  = 3'd4,
    OC_NORM      = 3'd5,
    OC_JUMP      = 3'd6
  } outcome_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               bus_ok;
    logic [7:0]         sensor_status;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] filt_x;
    logic signed [23:0] filt_y;
    logic signed [23:0] filt_z;
    outcome_t           outcome;
  } out_item_t;

  // A classified sample waiting for the back end.
  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    outcome_t           pre;
  } q_item_t;

  // Squared norm window, refreshed from the norm registers.
  typedef struct packed {
    logic [31:0] lo2;
    logic [31:0] hi2;
  } norm_win_t;

  // Settings used by the back end.
  typedef struct packed {
    logic [8:0]  alpha;
    logic [15:0] jump_limit;
    logic [15:0] poll_ms;
  } back_cfg_t;

endpackage

/* rtl/mors_front.sv */
// Front end: two-stage classifier for status bits and the squared-norm window.
// Depends on mors_pkg.
`timescale 1ns / 1ps

module mors_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  mors_pkg::in_item_t  item,
  input  mors_pkg::norm_win_t win,
  output logic                push,
  output mors_pkg::q_item_t   push_item,
  output logic [1:0]          inflight
);
  import mors_pkg::*;

  logic        s1_v_r;
  logic        s2_v_r;
  q_item_t     s1_r, s1_nxt;
  q_item_t     s2_r, s2_nxt;
  logic [30:0] sq_x_r, sq_y_r, sq_z_r;
  logic signed [31:0] px, py, pz;
  logic [32:0] n2;
  logic        norm_bad;

  always_comb begin
    px = 32'(item.raw_x) * 32'(item.raw_x);
    py = 32'(item.raw_y) * 32'(item.raw_y);
    pz = 32'(item.raw_z) * 32'(item.raw_z);
    s1_nxt.now_ms = item.now_ms;
    s1_nxt.raw_x  = item.raw_x;
    s1_nxt.raw_y  = item.raw_y;
    s1_nxt.raw_z  = item.raw_z;
    if (!item.bus_ok) begin
      s1_nxt.pre = OC_BUS_FAIL;
    end else if (!item.sensor_status[STATUS_DRDY_BIT]) begin
      s1_nxt.pre = OC_NOT_READY;
    end else if (item.sensor_status[STATUS_OVF_BIT]) begin
      s1_nxt.pre = OC_OVERFLOW;
    end else begin
      s1_nxt.pre = OC_UPDATED;
    end
  end

  always_comb begin
    n2 = {2'b00, sq_x_r} + {2'b00, sq_y_r} + {2'b00, sq_z_r};
    norm_bad = (n2 < {1'b0, win.lo2}) || (n2 > {1'b0, win.hi2});
    s2_nxt = s1_r;
    if (s1_r.pre == OC_UPDATED && norm_bad) begin
      s2_nxt.pre = OC_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= s1_nxt;
    sq_x_r <= px[30:0];
    sq_y_r <= py[30:0];
    sq_z_r <= pz[30:0];
    s2_r   <= s2_nxt;
  end

  assign push      = s2_v_r;
  assign push_item = s2_r;
  assign inflight  = {1'b0, s1_v_r} + {1'b0, s2_v_r};

endmodule

/* rtl/mors_queue.sv */
// Small flip-flop queue that decouples the classifier from the filter.
// Depends on mors_pkg.
`timescale 1ns / 1ps

module mors_queue #(
  parameter int DEPTH = mors_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  mors_pkg::q_item_t               push_item,
  input  logic                            pop,
  output logic                            head_valid,
  output mors_pkg::q_item_t               head_item,
  output logic [$clog2(DEPTH+1)-1:0]      count
);
  import mors_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign count      = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && count_r == CW'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && count_r == '0))
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

endmodule

/* rtl/mors_back.sv */
// Back end: poll timing, jump check, smoothing filter and the result register.
// Depends on mors_pkg.
`timescale 1ns / 1ps

module mors_back #(
  parameter int FRAC_BITS = mors_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mors_pkg::back_cfg_t cfg,
  input  logic                head_valid,
  input  mors_pkg::q_item_t   head_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mors_pkg::out_item_t out_data
);
  import mors_pkg::*;

  localparam int FW = 16 + FRAC_BITS;
  localparam int PW = FW + 11;

  logic                 have_r;
  logic [31:0]          next_poll_r;
  logic signed [15:0]   last_r   [3];
  logic signed [FW-1:0] filt_r   [3];
  logic signed [FW-1:0] filt_nxt [3];
  logic                 out_valid_r;
  out_item_t            out_r, out_nxt;

  logic signed [15:0]   raw      [3];
  logic signed [16:0]   dlt      [3];
  logic [16:0]          mag      [3];
  logic signed [FW-1:0] target   [3];
  logic signed [FW:0]   diff     [3];
  logic signed [PW-1:0] prod     [3];
  logic signed [PW-1:0] rnd      [3];
  logic signed [PW-1:0] shf      [3];
  logic signed [FW:0]   sum      [3];
  logic signed [FW+23:0] ext     [3];
  logic [2:0]           jb;
  logic [31:0]          since;
  logic                 due, jump_bad, all_zero, update;
  outcome_t             res_code;

  assign raw[0] = head_item.raw_x;
  assign raw[1] = head_item.raw_y;
  assign raw[2] = head_item.raw_z;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlt[i]    = {raw[i][15], raw[i]} - {last_r[i][15], last_r[i]};
      mag[i]    = dlt[i][16] ? 17'(-dlt[i]) : 17'(dlt[i]);
      jb[i]     = mag[i] > {1'b0, cfg.jump_limit};
      target[i] = {raw[i], {FRAC_BITS{1'b0}}};
      diff[i]   = {target[i][FW-1], target[i]} - {filt_r[i][FW-1], filt_r[i]};
      prod[i]   = PW'($signed({1'b0, cfg.alpha})) * PW'(diff[i]);
      rnd[i]    = prod[i] + PW'(128);
      shf[i]    = rnd[i] >>> 8;
      sum[i]    = {filt_r[i][FW-1], filt_r[i]} + shf[i][FW:0];
    end
    all_zero = (filt_r[0] == '0) && (filt_r[1] == '0) && (filt_r[2] == '0);
    since    = head_item.now_ms - next_poll_r;
    due      = !have_r || !since[31];
    jump_bad = have_r && (|jb);

    if (!due) begin
      res_code = OC_NOT_DUE;
    end else if (head_item.pre != OC_UPDATED) begin
      res_code = head_item.pre;
    end else if (jump_bad) begin
      res_code = OC_JUMP;
    end else begin
      res_code = OC_UPDATED;
    end
    update = (res_code == OC_UPDATED);

    for (int i = 0; i < 3; i++) begin
      if (!update) begin
        filt_nxt[i] = filt_r[i];
      end else if (all_zero) begin
        filt_nxt[i] = target[i];
      end else begin
        filt_nxt[i] = sum[i][FW-1:0];
      end
      ext[i] = (FW + 24)'(filt_nxt[i]);
    end

    out_nxt.filt_x  = ext[0][23:0];
    out_nxt.filt_y  = ext[1][23:0];
    out_nxt.filt_z  = ext[2][23:0];
    out_nxt.outcome = res_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      next_poll_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        last_r[i] <= '0;
        filt_r[i] <= '0;
      end
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop && due) begin
        next_poll_r <= head_item.now_ms + {16'd0, cfg.poll_ms};
      end
      if (pop && update) begin
        have_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          last_r[i] <= raw[i];
          filt_r[i] <= filt_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_update_sets_have: assert property (@(posedge clk) disable iff (!rst_n)
    pop && res_code == OC_UPDATED |=> have_r)
    else $error("accepted sample did not mark the filter as primed");

  a_hold_without_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(have_r) && $stable(next_poll_r))
    else $error("filter state moved without a transaction");

  a_not_due_keeps_poll: assert property (@(posedge clk) disable iff (!rst_n)
    pop && res_code == OC_NOT_DUE |=> $stable(next_poll_r) && $stable(filt_r[0]))
    else $error("item that was not due changed poll time or filter");

endmodule

/* rtl/magnetometer_outlier_reject_smoother.sv */
// Top level of the magnetometer outlier-reject smoother: configuration
// registers, front classifier, queue and filter back end. Depends on mors_pkg,
// mors_front, mors_queue and mors_back.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle on the input channel while
// in_stall is low and returns exactly one result transaction for each, in
// order. An accepted input passes through two front stages (status checks,
// then the squared-norm window), one queue entry, and the back end that
// updates the filter and loads the result register. The back end updates its
// poll-time, jump and filter state for each item with a single multiply-add
// per axis, and takes the next item whenever its result register is empty or
// being read. The input stalls only when the queue together with the items
// still in the front stages has reached QUEUE_DEPTH, so a result waiting on a
// stalled output does not stop new inputs until the queue fills.
// The filtered vector is reported in raw counts with FRAC_BITS fraction bits;
// the filter itself is kept at 16 + FRAC_BITS bits and the output fields are
// its low 24 bits, sign-extended when FRAC_BITS is below 8. The configuration
// port is always ready; registers should be written only while no transaction
// is in flight. The squared norm limits are registered from the norm
// registers and follow a norm register write in the cycle after it. An alpha
// above 256 acts as 256, so a sample then replaces the average outright.
module magnetometer_outlier_reject_smoother #(
  parameter int FRAC_BITS   = mors_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = mors_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mors_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mors_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mors_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mors_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mors_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [8:0]  alpha_r;
  logic [15:0] norm_min_r, norm_max_r, jump_r, poll_r;
  norm_win_t   win_r, win_nxt;
  back_cfg_t   back_cfg;

  logic        in_accept;
  logic        push, pop, head_valid;
  q_item_t     push_item, head_item;
  logic [1:0]  inflight;
  logic [CW-1:0] q_count;
  logic [CW:0] occupancy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r    <= ALPHA_RESET;
      norm_min_r <= NORM_MIN_RESET;
      norm_max_r <= NORM_MAX_RESET;
      jump_r     <= JUMP_RESET;
      poll_r     <= POLL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALPHA_Q8:      alpha_r    <= cfg_data[8:0];
        CFG_NORM_MIN:      norm_min_r <= cfg_data;
        CFG_NORM_MAX:      norm_max_r <= cfg_data;
        CFG_JUMP_LIMIT:    jump_r     <= cfg_data;
        CFG_POLL_INTERVAL: poll_r     <= cfg_data;
        default: begin
          // Indexes past the register list are ignored.
        end
      endcase
    end
  end

  // The norm window is compared on squares, so the limits are squared once
  // here and held in registers rather than per item.
  always_comb begin
    win_nxt.lo2 = 32'(norm_min_r) * 32'(norm_min_r);
    win_nxt.hi2 = 32'(norm_max_r) * 32'(norm_max_r);
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_comb begin
    back_cfg.alpha      = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
    back_cfg.jump_limit = jump_r;
    back_cfg.poll_ms    = poll_r;
  end

  // Credit check: every item in the front stages already owns a queue slot.
  assign occupancy = {1'b0, q_count} + (CW + 1)'(inflight);
  assign in_stall  = (occupancy >= (CW + 1)'(QUEUE_DEPTH));
  assign in_accept = in_valid && !in_stall;

  mors_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .item      (in_data),
    .win       (win_r),
    .push      (push),
    .push_item (push_item),
    .inflight  (inflight)
  );

  mors_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  mors_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (back_cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the magnetometer outlier-reject smoother.
// Depends on mors_pkg and magnetometer_outlier_reject_smoother from rtl/.
`timescale 1ns / 1ps

module testbench;
  import mors_pkg::*;

  // Filter fraction bits of the instance under test and the Q1.8 shift of alpha.
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int ALPHA_SHIFT = 8;
  // Extra settle time after the last result, before registers are written.
  localparam int SETTLE_CYCLES = 8;
  // The long receiver hold-off and the watchdog that bounds any silent stretch.
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  magnetometer_outlier_reject_smoother u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Readings waiting to be offered, and the filter outputs we expect back in order.
  in_item_t pending_readings[$];
  out_item_t expected_filt[$];
  out_item_t oldest_expected;

  int queued_count = 0;
  int sent_count = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // Idle rates in percent, changed by the sequencer between groups of phases.
  int send_idle_pct = 27;
  int recv_idle_pct = 80;

  int hold_left = 0;
  bit hold_done = 1'b0;

  // Time base used by the random generator.
  logic [31:0] gen_now = '0;

  // Our own copy of the configuration registers, reset to their documented values.
  logic [8:0] reg_alpha = ALPHA_RESET;
  logic [15:0] reg_norm_min = NORM_MIN_RESET;
  logic [15:0] reg_norm_max = NORM_MAX_RESET;
  logic [15:0] reg_jump = JUMP_RESET;
  logic [15:0] reg_poll = POLL_RESET;

  // Our own copy of the smoother state. The filter is held at full width.
  bit prd_have = 1'b0;
  logic [31:0] prd_next_poll = '0;
  longint prd_last[3] = '{0, 0, 0};
  longint prd_filt[3] = '{0, 0, 0};

  // Runs one reading through the gate and the moving average and returns the
  // result transaction the block should produce for it. The checks go in
  // outcome order: poll time, bus, data ready, overflow, norm window, jump.
  function automatic out_item_t advance_smoother(in_item_t s);
    out_item_t r;
    outcome_t oc;
    longint raw[3];
    longint n2, lo, hi, d, a, p;
    logic [31:0] lag;
    bit jumped;
    int i;

    raw[0] = longint'(s.raw_x);
    raw[1] = longint'(s.raw_y);
    raw[2] = longint'(s.raw_z);
    lag = s.now_ms - prd_next_poll;

    // Before the first accepted sample every reading counts as due. After it,
    // a reading whose wrapped distance to the poll time is negative is early.
    if (prd_have && lag[31]) begin
      oc = OC_NOT_DUE;
    end else begin
      prd_next_poll = s.now_ms + 32'(reg_poll);
      if (!s.bus_ok) begin
        oc = OC_BUS_FAIL;
      end else if (!s.sensor_status[STATUS_DRDY_BIT]) begin
        oc = OC_NOT_READY;
      end else if (s.sensor_status[STATUS_OVF_BIT]) begin
        oc = OC_OVERFLOW;
      end else begin
        // Squared magnitudes are compared exactly, so no square root is needed.
        // With the lower bound above the upper one nothing can pass.
        n2 = raw[0] * raw[0] + raw[1] * raw[1] + raw[2] * raw[2];
        lo = longint'(reg_norm_min);
        hi = longint'(reg_norm_max);
        jumped = 1'b0;
        if (prd_have) begin
          for (i = 0; i < 3; i++) begin
            d = raw[i] - prd_last[i];
            if (d < 0) d = -d;
            if (d > longint'(reg_jump)) jumped = 1'b1;
          end
        end
        if (n2 < lo * lo || n2 > hi * hi) begin
          oc = OC_NORM;
        end else if (jumped) begin
          oc = OC_JUMP;
        end else begin
          oc = OC_UPDATED;
          prd_have = 1'b1;
          a = longint'((reg_alpha > ALPHA_ONE) ? ALPHA_ONE : reg_alpha);
          if (prd_filt[0] == 0 && prd_filt[1] == 0 && prd_filt[2] == 0) begin
            // An all-zero average is seeded directly with the sample.
            for (i = 0; i < 3; i++) prd_filt[i] = raw[i] * (longint'(1) << FRAC);
          end else begin
            // Step is floor((alpha * diff + 128) / 256): round to nearest, ties up.
            for (i = 0; i < 3; i++) begin
              d = raw[i] * (longint'(1) << FRAC) - prd_filt[i];
              p = a * d + 128;
              prd_filt[i] = prd_filt[i] + (p >>> ALPHA_SHIFT);
            end
          end
          for (i = 0; i < 3; i++) prd_last[i] = raw[i];
        end
      end
    end

    r.filt_x = 24'(prd_filt[0]);
    r.filt_y = 24'(prd_filt[1]);
    r.filt_z = 24'(prd_filt[2]);
    r.outcome = oc;
    return r;
  endfunction

  // Driver: offers the next pending reading, holds it steady while stalled,
  // and predicts the result at the edge where the transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_filt.push_back(advance_smoother(in_data));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_readings.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic signed [23:0] want, logic signed [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: every accepted result transaction is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_filt.size() == 0) begin
        $error("result transaction with nothing expected, outcome %0d", out_data.outcome);
        mismatch_count++;
      end else begin
        oldest_expected = expected_filt.pop_front();
        check_field("filt_x", oldest_expected.filt_x, out_data.filt_x);
        check_field("filt_y", oldest_expected.filt_y, out_data.filt_y);
        check_field("filt_z", oldest_expected.filt_z, out_data.filt_z);
        check_field("outcome", 24'(oldest_expected.outcome), 24'(out_data.outcome));
      end
    end
  end

  // Receiver stall. Once, after a few hundred results, the receiver holds off
  // for a long stretch so that the queue fills and the block stalls its input
  // while the sender keeps offering readings.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any stretch without a single transaction on any channel that
  // outlasts the limit means the block has hung or lost a result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_reading(logic [31:0] stamp, bit bus, logic [7:0] st, int x, int y, int z);
    in_item_t s;
    s.now_ms = stamp;
    s.bus_ok = bus;
    s.sensor_status = st;
    s.raw_x = 16'(x);
    s.raw_y = 16'(y);
    s.raw_z = 16'(z);
    pending_readings.push_back(s);
    queued_count++;
  endtask

  // Waits until every queued reading has been accepted and answered, then lets
  // the pipeline settle before the registers may be touched.
  task automatic drain_and_settle();
    while (sent_count != queued_count || expected_filt.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA_Q8: reg_alpha = val[8:0];
      CFG_NORM_MIN: reg_norm_min = val;
      CFG_NORM_MAX: reg_norm_max = val;
      CFG_JUMP_LIMIT: reg_jump = val;
      CFG_POLL_INTERVAL: reg_poll = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(int alpha, int nmin, int nmax, int jump, int poll);
    drain_and_settle();
    write_reg(CFG_ALPHA_Q8, 16'(alpha));
    write_reg(CFG_NORM_MIN, 16'(nmin));
    write_reg(CFG_NORM_MAX, 16'(nmax));
    write_reg(CFG_JUMP_LIMIT, 16'(jump));
    write_reg(CFG_POLL_INTERVAL, 16'(poll));
  endtask

  // Random readings around a slowly re-picked field vector. Most are clean
  // samples with time advancing on the order of the poll interval; a few jump
  // far ahead in time, arrive stamped far in the past, fail on the bus or the
  // status bits, or carry a spike on one axis or a wholly random vector.
  task automatic queue_random_readings(int count, int span, int noise, int poll);
    int field[3];
    int raw[3];
    int n, i, roll, v;
    logic [31:0] stamp;
    logic [7:0] st;
    bit bus;

    for (i = 0; i < 3; i++) field[i] = int'($urandom_range(2 * span)) - span;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 2) begin
        for (i = 0; i < 3; i++) field[i] = int'($urandom_range(2 * span)) - span;
      end

      roll = $urandom_range(99);
      if (roll < 3) gen_now += $urandom_range(32'h4000_0000);
      else if (roll >= 6) gen_now += $urandom_range(2 * poll + 2);
      stamp = (roll >= 3 && roll < 6) ? gen_now - $urandom_range(1, 32'h4000_0000) : gen_now;

      bus = ($urandom_range(99) >= 4);
      st = 8'($urandom);
      if ($urandom_range(99) >= 6) begin
        st[STATUS_DRDY_BIT] = 1'b1;
        st[STATUS_OVF_BIT] = 1'b0;
      end

      roll = $urandom_range(99);
      for (i = 0; i < 3; i++) begin
        if (roll < 3) begin
          v = int'($signed(16'($urandom)));
        end else begin
          v = field[i] + int'($urandom_range(2 * noise)) - noise;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
        raw[i] = v;
      end
      if (roll >= 3 && roll < 8) raw[$urandom_range(2)] = int'($signed(16'($urandom)));

      queue_reading(stamp, bus, st, raw[0], raw[1], raw[2]);
    end
  endtask

  // Sequencer: reset, a directed pass over the special cases, then random
  // phases under several register settings and three idling patterns.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: the first readings are all due because nothing has been
    // accepted yet, so each rejection reason shows up in turn.
    queue_reading(32'd0, 1'b0, 8'h01, 100, 200, -300);
    queue_reading(32'd0, 1'b1, 8'h00, 100, 200, -300);
    queue_reading(32'd1, 1'b1, 8'h03, 100, 200, -300);
    queue_reading(32'd2, 1'b1, 8'hFD, 0, 0, 0);
    queue_reading(32'd3, 1'b1, 8'h01, 32767, -32768, 32767);
    // First accepted sample seeds the average; early readings only echo it.
    queue_reading(32'd5, 1'b1, 8'h01, 100, 200, -300);
    queue_reading(32'd10, 1'b1, 8'h01, 100, 200, -300);
    queue_reading(32'd34, 1'b1, 8'h01, 100, 200, -300);
    queue_reading(32'd35, 1'b1, 8'h01, 110, 190, -290);
    // Both edges of the norm window, just inside and just outside.
    queue_reading(32'd70, 1'b1, 8'h01, 140, 0, 0);
    queue_reading(32'd100, 1'b1, 8'h01, 1300, 0, 0);
    queue_reading(32'd130, 1'b1, 8'h01, 1301, 0, 0);
    queue_reading(32'd160, 1'b1, 8'h01, 0, -139, 0);
    // Time stamps that wrap through zero, and one far behind the poll time.
    queue_reading(32'h7FFF_0000, 1'b1, 8'h01, -600, 500, 300);
    queue_reading(32'hFFFF_FFF0, 1'b1, 8'h01, -610, 510, 290);
    queue_reading(32'h0000_000D, 1'b1, 8'h01, -620, 520, 280);
    queue_reading(32'h0000_000E, 1'b1, 8'h01, -620, 520, 280);
    queue_reading(32'h8000_0030, 1'b1, 8'h01, -620, 520, 280);

    // Full weight and a wide-open window: the sample replaces the average,
    // and a zero sample drives the average back to all zero.
    apply_settings(256, 0, 65535, 65535, 0);
    queue_reading(32'h100, 1'b1, 8'h01, -32768, 32767, -32768);
    queue_reading(32'h100, 1'b1, 8'h01, 0, 0, 0);
    // Lower bound above the upper bound rejects everything; longest interval.
    apply_settings(1, 1000, 500, 0, 65535);
    queue_reading(32'h200, 1'b1, 8'h01, 500, 0, 0);
    queue_reading(32'h300, 1'b1, 8'h01, 500, 0, 0);
    // A zero jump limit passes only an identical sample.
    apply_settings(1, 0, 65535, 0, 65535);
    queue_reading(32'h1_0200, 1'b1, 8'h01, 0, 0, 0);
    queue_reading(32'h2_0200, 1'b1, 8'h01, 1, 0, 0);
    // With the average at zero the next sample loads directly even at a tiny weight.
    apply_settings(1, 0, 65535, 65535, 0);
    queue_reading(32'h3_0200, 1'b1, 8'h01, 500, -7, 3);
    queue_reading(32'h3_0200, 1'b1, 8'h01, -500, 7, -3);
    gen_now = 32'h3_0200;

    // Sender idles lightly while the receiver stalls most of the time.
    apply_settings(46, 140, 1300, 4000, 30);
    queue_random_readings(240, 600, 40, 30);
    apply_settings(511, 0, 65535, 65535, 0);
    queue_random_readings(240, 32767, 2000, 0);

    // The other way round.
    drain_and_settle();
    send_idle_pct = 80;
    recv_idle_pct = 27;
    apply_settings(0, 100, 2000, 50, 5);
    queue_random_readings(240, 900, 20, 5);
    apply_settings(1, 0, 3000, 700, 1);
    queue_random_readings(240, 1500, 300, 1);

    // Neither side idles.
    drain_and_settle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(200, 1000, 500, 100, 65535);
    queue_random_readings(100, 800, 50, 65535);
    apply_settings(128, 65535, 65535, 65535, 10);
    queue_random_readings(100, 32767, 100, 10);
    apply_settings(46, 140, 1300, 4000, 30);
    queue_random_readings(240, 600, 40, 30);

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
